### hw/rtl/cffis_pkg.sv
package cffis_pkg;

    // Input mode codes
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLOSE  = 2'd1;
    localparam logic [1:0] MODE_PULL   = 2'd2;

    // Command kinds passed from the front to the back
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_CLOSE  = 2'd1;
    localparam logic [1:0] CMD_PULL   = 2'd2;

    // Offset size thresholds
    localparam logic [31:0] LIM_1B = 32'h0000_00ff;
    localparam logic [31:0] LIM_2B = 32'h0000_ffff;
    localparam logic [31:0] LIM_3B = 32'h00ff_ffff;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } cmd_t;

    // Fewest bytes (1 to 4) that hold the given total
    function automatic logic [2:0] offset_size(input logic [31:0] total);
        logic [2:0] size;
        if (total <= LIM_1B) begin
            size = 3'd1;
        end else if (total <= LIM_2B) begin
            size = 3'd2;
        end else if (total <= LIM_3B) begin
            size = 3'd3;
        end else begin
            size = 3'd4;
        end
        return size;
    endfunction

endpackage

### hw/rtl/cffis_front.sv
module cffis_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [7:0]        s_data_byte,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cffis_pkg::cmd_t   cmd
);

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    cffis_pkg::cmd_t q_reg [QDEPTH];
    logic [QAW:0]    wr_ptr_reg, wr_ptr_next;
    logic [QAW:0]    rd_ptr_reg, rd_ptr_next;
    logic            full, empty;
    logic            push, pop, keep;
    cffis_pkg::cmd_t cls;

    // Classify the incoming word; undefined modes are dropped here
    always_comb begin
        cls.data_byte = s_data_byte;
        cls.kind      = cffis_pkg::CMD_APPEND;
        keep          = 1'b1;
        unique case (s_mode)
            cffis_pkg::MODE_APPEND: cls.kind = cffis_pkg::CMD_APPEND;
            cffis_pkg::MODE_CLOSE:  cls.kind = cffis_pkg::CMD_CLOSE;
            cffis_pkg::MODE_PULL:   cls.kind = cffis_pkg::CMD_PULL;
            default:                keep     = 1'b0;
        endcase
    end

    assign full  = (wr_ptr_reg[QAW] != rd_ptr_reg[QAW]) &&
                   (wr_ptr_reg[QAW-1:0] == rd_ptr_reg[QAW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    assign s_ready   = !full;
    assign cmd_valid = !empty;
    assign cmd       = q_reg[rd_ptr_reg[QAW-1:0]];

    assign push = s_valid && s_ready && keep;
    assign pop  = cmd_valid && cmd_ready;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;

    // Advance queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg[QAW-1:0]] <= cls;
        end
    end

endmodule

### hw/rtl/cffis_back.sv
module cffis_back #(
    parameter int MAX_MEMBERS = 256,
    parameter int DATA_BYTES  = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cffis_pkg::cmd_t   cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_byte,
    output logic              m_last,
    output logic              m_overflow
);

    localparam int MCW = $clog2(MAX_MEMBERS + 1);
    localparam int FPW = $clog2(DATA_BYTES + 1);
    localparam int EPW = (FPW > MCW) ? FPW : MCW;
    localparam int MAW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int DAW = $clog2(DATA_BYTES);

    localparam logic       S_EXEC = 1'b0;
    localparam logic       S_EMIT = 1'b1;

    localparam logic [2:0] PH_LOAD   = 3'd0;
    localparam logic [2:0] PH_CNT_HI = 3'd1;
    localparam logic [2:0] PH_CNT_LO = 3'd2;
    localparam logic [2:0] PH_OSIZE  = 3'd3;
    localparam logic [2:0] PH_OFFS   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;

    localparam logic [MCW-1:0] MAX_CNT  = MCW'(MAX_MEMBERS);
    localparam logic [FPW-1:0] MAX_FILL = FPW'(DATA_BYTES);

    logic [7:0]     data_mem [DATA_BYTES];
    logic [FPW-1:0] ends_mem [MAX_MEMBERS];
    logic [7:0]     data_rd_reg;
    logic [FPW-1:0] ends_rd_reg;

    logic           state_reg, state_next;
    logic [2:0]     phase_reg, phase_next;
    logic [MCW-1:0] count_reg, count_next;
    logic [FPW-1:0] fill_reg, fill_next;
    logic [FPW-1:0] last_end_reg, last_end_next;
    logic [EPW-1:0] pos_reg, pos_next;
    logic [1:0]     obi_reg, obi_next;
    logic           ovf_reg, ovf_next;

    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_byte_reg;
    logic           m_last_reg, m_ovf_reg;

    logic           data_we, ends_we;
    logic [EPW-1:0] pos_m1;
    logic [2:0]     osize;
    logic [31:0]    off_val;
    logic           out_free, emit_fire;
    logic [7:0]     val;
    logic           last_val;
    logic           pos_at_end;
    logic           data_done;

    assign cmd_ready = (state_reg == S_EXEC);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = (state_reg == S_EMIT) && out_free;

    assign pos_m1     = pos_reg - 1'b1;
    assign osize      = cffis_pkg::offset_size(32'(fill_reg) + 32'd1);
    assign off_val    = (pos_reg != '0) ? 32'(ends_rd_reg) + 32'd1 : 32'd1;
    assign pos_at_end = ((EPW+1)'(pos_reg) >= (EPW+1)'(count_reg));
    assign data_done  = ((EPW+1)'(pos_reg) + 1'b1 >= (EPW+1)'(fill_reg));

    // Execute commands and step the emit sequence
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        fill_next     = fill_reg;
        last_end_next = last_end_reg;
        pos_next      = pos_reg;
        obi_next      = obi_reg;
        ovf_next      = ovf_reg;
        data_we       = 1'b0;
        ends_we       = 1'b0;
        val           = 8'h00;
        last_val      = 1'b0;

        unique case (state_reg)
            S_EXEC: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        cffis_pkg::CMD_APPEND: begin
                            if (phase_reg == PH_LOAD) begin
                                if (count_reg >= MAX_CNT || fill_reg >= MAX_FILL) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    data_we   = 1'b1;
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                        cffis_pkg::CMD_CLOSE: begin
                            if (phase_reg == PH_LOAD) begin
                                if (count_reg >= MAX_CNT) begin
                                    ovf_next = 1'b1;
                                end else begin
                                    ends_we       = 1'b1;
                                    count_next    = count_reg + 1'b1;
                                    last_end_next = fill_reg;
                                end
                            end
                        end
                        cffis_pkg::CMD_PULL: begin
                            // close a pending member before the first byte goes out
                            if (phase_reg == PH_LOAD) begin
                                if (fill_reg > last_end_reg && count_reg < MAX_CNT) begin
                                    ends_we       = 1'b1;
                                    count_next    = count_reg + 1'b1;
                                    last_end_next = fill_reg;
                                end
                                phase_next = PH_CNT_HI;
                            end
                            state_next = S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_EXEC;
                    unique case (phase_reg)
                        PH_CNT_HI: begin
                            val        = 8'(16'(count_reg) >> 8);
                            phase_next = PH_CNT_LO;
                        end
                        PH_CNT_LO: begin
                            val = 8'(count_reg);
                            if (count_reg == '0) begin
                                last_val = 1'b1;
                            end else begin
                                phase_next = PH_OSIZE;
                            end
                        end
                        PH_OSIZE: begin
                            val        = 8'(osize);
                            phase_next = PH_OFFS;
                            pos_next   = '0;
                            obi_next   = 2'(osize - 3'd1);
                        end
                        PH_OFFS: begin
                            case (obi_reg)
                                2'd0:    val = off_val[7:0];
                                2'd1:    val = off_val[15:8];
                                2'd2:    val = off_val[23:16];
                                default: val = off_val[31:24];
                            endcase
                            if (obi_reg != 2'd0) begin
                                obi_next = obi_reg - 1'b1;
                            end else if (pos_at_end) begin
                                if (fill_reg == '0) begin
                                    last_val = 1'b1;
                                end else begin
                                    phase_next = PH_DATA;
                                    pos_next   = '0;
                                end
                            end else begin
                                pos_next = pos_reg + 1'b1;
                                obi_next = 2'(osize - 3'd1);
                            end
                        end
                        PH_DATA: begin
                            val      = data_rd_reg;
                            pos_next = pos_reg + 1'b1;
                            last_val = data_done;
                        end
                        default: phase_next = PH_LOAD;
                    endcase
                    // clear the control state after the final byte
                    if (last_val) begin
                        phase_next    = PH_LOAD;
                        count_next    = '0;
                        fill_next     = '0;
                        last_end_next = '0;
                        pos_next      = '0;
                        obi_next      = '0;
                        ovf_next      = 1'b0;
                    end
                end
            end
            default: state_next = S_EXEC;
        endcase
    end

    // Drop the result word once taken, load a new one on emit
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_EXEC;
            phase_reg    <= PH_LOAD;
            count_reg    <= '0;
            fill_reg     <= '0;
            last_end_reg <= '0;
            pos_reg      <= '0;
            obi_reg      <= '0;
            ovf_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fill_reg     <= fill_next;
            last_end_reg <= last_end_next;
            pos_reg      <= pos_next;
            obi_reg      <= obi_next;
            ovf_reg      <= ovf_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_byte_reg <= val;
            m_last_reg <= last_val;
            m_ovf_reg  <= ovf_reg;
        end
    end

    // Member data store
    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[fill_reg[DAW-1:0]] <= cmd.data_byte;
        end
        data_rd_reg <= data_mem[pos_reg[DAW-1:0]];
    end

    // Member end store
    always_ff @(posedge aclk) begin
        if (ends_we) begin
            ends_mem[count_reg[MAW-1:0]] <= fill_reg;
        end
        ends_rd_reg <= ends_mem[pos_m1[MAW-1:0]];
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_last     = m_last_reg;
    assign m_overflow = m_ovf_reg;

    // Final byte leaves the block empty and loading
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && last_val |=> phase_reg == PH_LOAD && count_reg == '0 && fill_reg == '0)
        else $error("block not cleared after final byte");

    // A pull being emitted is never in the loading phase
    a_emit_not_loading: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> phase_reg != PH_LOAD)
        else $error("emit cycle while loading");

    // Offset walk stays within the closed members
    a_offs_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_OFFS |-> (EPW+1)'(pos_reg) <= (EPW+1)'(count_reg))
        else $error("offset position past member count");

    // Data walk stays below the fill pointer
    a_data_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> (EPW+1)'(pos_reg) < (EPW+1)'(fill_reg))
        else $error("data position past fill pointer");

endmodule

### hw/rtl/cff_index_serializer.sv
// CFF INDEX serializer.
// Input channel (s_valid/s_ready, s_mode, s_data_byte): mode 0 appends a byte
// to the current member, mode 1 closes the member, mode 2 pulls the next byte
// of the serialized INDEX, mode 3 is taken and ignored.
// Result channel (m_valid/m_ready, m_out_byte, m_last, m_overflow): one word
// per pull: count (2 bytes), offset size, offsets, then member data. m_last
// marks the final byte; the block then clears itself and loads anew.
// Timing: input words go into a 4-entry command queue. Append and close words
// retire at one per cycle while the back end is free; a pull moves the back end
// from its execute state to its emit state, where its result word is loaded,
// and the back end takes no new command until it leaves the emit state.
// The result register is reloaded as its word is taken; when the
// receiver stalls, the back end holds and the queue fills, then s_ready drops.
// Reset (aresetn low, synchronous) empties the queue and result register and
// returns to the loading phase with no members. Memory contents are not
// cleared; only written entries are ever used.
module cff_index_serializer #(
    parameter int MAX_MEMBERS = 256,
    parameter int DATA_BYTES  = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last,
    output logic       m_overflow
);

    logic            cmd_valid;
    logic            cmd_ready;
    cffis_pkg::cmd_t cmd;

    cffis_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_byte (s_data_byte),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    cffis_back #(
        .MAX_MEMBERS (MAX_MEMBERS),
        .DATA_BYTES  (DATA_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .m_overflow (m_overflow)
    );

endmodule

### bench/cff_index_serializer_check.sv
module cff_index_serializer_check #(
    parameter int MAX_MEMBERS = 256,
    parameter int DATA_BYTES  = 4096
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [1:0] s_mode,
    input  logic [7:0] s_data_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_last,
    input  logic       m_overflow,
    output int         errors,
    output int         pending,
    output logic       emitting,
    output int         items_taken,
    output int         words_checked,
    output int         indexes_done,
    output int         dropped_indexes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        PH_LOAD,
        PH_COUNT_HI,
        PH_COUNT_LO,
        PH_OFFSET_SIZE,
        PH_OFFSETS,
        PH_DATA
    } emit_phase_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       overflow;
    } index_byte_t;

    // Shadow copy of the INDEX under construction
    logic [7:0]   data_mem [DATA_BYTES];
    logic [12:0]  end_mem [MAX_MEMBERS];
    int unsigned  n_members;
    int unsigned  fill;
    int unsigned  pos;
    int unsigned  byte_sel;
    logic         dropped;
    emit_phase_t  phase;
    index_byte_t  index_bytes_due[$];

    // Fewest offset bytes that can hold the given total
    function automatic int unsigned offset_bytes(input int unsigned total);
        if (total <= 'hff) begin
            return 1;
        end else if (total <= 'hffff) begin
            return 2;
        end else if (total <= 'hffffff) begin
            return 3;
        end
        return 4;
    endfunction

    // Back to an empty loading state; stored bytes are left as they are
    function automatic void clear_index();
        n_members = 0;
        fill      = 0;
        pos       = 0;
        byte_sel  = 0;
        dropped   = 1'b0;
        phase     = PH_LOAD;
    endfunction

    always @(posedge aclk) begin : watch
        index_byte_t word;
        int unsigned closed;
        logic [31:0] off;
        logic        produce;
        if (!aresetn) begin
            clear_index();
            index_bytes_due.delete();
        end else begin
            // compare a delivered word with the oldest predicted byte
            if (m_valid && m_ready) begin
                words_checked++;
                if (index_bytes_due.size() == 0) begin
                    errors++;
                    $display("%0.0f ns: unexpected word, out_byte %02h last %0b overflow %0b",
                             $realtime, m_out_byte, m_last, m_overflow);
                end else begin
                    word = index_bytes_due.pop_front();
                    if (m_out_byte !== word.value) begin
                        errors++;
                        $display("%0.0f ns: out_byte expected %02h, got %02h",
                                 $realtime, word.value, m_out_byte);
                    end
                    if (m_last !== word.last) begin
                        errors++;
                        $display("%0.0f ns: last expected %0b, got %0b",
                                 $realtime, word.last, m_last);
                    end
                    if (m_overflow !== word.overflow) begin
                        errors++;
                        $display("%0.0f ns: overflow expected %0b, got %0b",
                                 $realtime, word.overflow, m_overflow);
                    end
                end
            end

            // advance the model on each accepted word; mode 3 is dropped
            produce = 1'b0;
            if (s_valid && s_ready && (s_mode inside {cffis_pkg::MODE_APPEND,
                    cffis_pkg::MODE_CLOSE, cffis_pkg::MODE_PULL})) begin
                if (phase == PH_LOAD) begin
                    items_taken++;
                    if (s_mode == cffis_pkg::MODE_APPEND) begin
                        if (n_members >= MAX_MEMBERS || fill >= DATA_BYTES) begin
                            dropped = 1'b1;
                        end else begin
                            data_mem[fill] = s_data_byte;
                            fill++;
                        end
                    end else if (s_mode == cffis_pkg::MODE_CLOSE) begin
                        if (n_members >= MAX_MEMBERS) begin
                            dropped = 1'b1;
                        end else begin
                            end_mem[n_members] = 13'(fill);
                            n_members++;
                        end
                    end else begin
                        // close an open member that holds bytes before emitting
                        closed = (n_members == 0) ? 0 : end_mem[n_members - 1];
                        if (fill > closed && n_members < MAX_MEMBERS) begin
                            end_mem[n_members] = 13'(fill);
                            n_members++;
                        end
                        phase   = PH_COUNT_HI;
                        produce = 1'b1;
                    end
                end else if (s_mode == cffis_pkg::MODE_PULL) begin
                    items_taken++;
                    produce = 1'b1;
                end
            end

            // emit the next byte of the serialized INDEX
            if (produce) begin
                word.last = 1'b0;
                case (phase)
                    PH_COUNT_HI: begin
                        word.value = 8'(n_members >> 8);
                        phase      = PH_COUNT_LO;
                    end
                    PH_COUNT_LO: begin
                        word.value = 8'(n_members);
                        if (n_members == 0)
                            word.last = 1'b1;
                        else
                            phase = PH_OFFSET_SIZE;
                    end
                    PH_OFFSET_SIZE: begin
                        word.value = 8'(offset_bytes(fill + 1));
                        phase      = PH_OFFSETS;
                        pos        = 0;
                        byte_sel   = offset_bytes(fill + 1) - 1;
                    end
                    PH_OFFSETS: begin
                        off = 32'd1;
                        if (pos > 0)
                            off += end_mem[pos - 1];
                        word.value = 8'(off >> (8 * byte_sel));
                        if (byte_sel > 0) begin
                            byte_sel--;
                        end else if (pos >= n_members) begin
                            if (fill == 0) begin
                                word.last = 1'b1;
                            end else begin
                                phase = PH_DATA;
                                pos   = 0;
                            end
                        end else begin
                            pos++;
                            byte_sel = offset_bytes(fill + 1) - 1;
                        end
                    end
                    default: begin
                        word.value = data_mem[pos];
                        pos++;
                        if (pos >= fill)
                            word.last = 1'b1;
                    end
                endcase
                word.overflow = dropped;
                index_bytes_due = {index_bytes_due, word};
                if (word.last) begin
                    indexes_done++;
                    dropped_indexes += dropped;
                    clear_index();
                end
            end
        end
        pending  = index_bytes_due.size();
        emitting = (phase != PH_LOAD);
    end

endmodule

### bench/cff_index_serializer_test.sv
module cff_index_serializer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_MEMBERS  = 256;
    localparam int DATA_BYTES   = 4096;
    localparam int PHASE_ITEMS  = 75;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [1:0] MODE_IGNORED = 2'd3;

    logic       aclk;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [1:0] s_mode      = cffis_pkg::MODE_APPEND;
    logic [7:0] s_data_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_last;
    logic       m_overflow;

    int   errors;
    int   pending;
    logic emitting;
    int   items_taken;
    int   words_checked;
    int   indexes_done;
    int   dropped_indexes;

    int gap_pct   = 0;
    int stall_pct = 0;
    int cycles    = 0;
    int gap_plan[4]   = '{0, 54, 0, 29};
    int stall_plan[4] = '{0, 0, 54, 29};

    cff_index_serializer #(
        .MAX_MEMBERS(MAX_MEMBERS),
        .DATA_BYTES (DATA_BYTES)
    ) u_top (.*);

    cff_index_serializer_check #(
        .MAX_MEMBERS(MAX_MEMBERS),
        .DATA_BYTES (DATA_BYTES)
    ) u_check (.*);

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // random receiver stalls
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // hard stop if the block hangs
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
            $display("simulation failed");
            $finish;
        end
    end

    // Present one word, hold it until taken; called and returns at a falling edge
    task automatic send_word(input logic [1:0] mode, input logic [7:0] data);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_data_byte <= data;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    // Append len random bytes, with stray ignored words mixed in, then close if close_it
    task automatic load_member(input int len, input logic close_it);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0)
                send_word(MODE_IGNORED, 8'($urandom));
            send_word(cffis_pkg::MODE_APPEND, 8'($urandom));
        end
        if (close_it)
            send_word(cffis_pkg::MODE_CLOSE, 8'($urandom));
    endtask

    // Pull until the whole INDEX is out, with loading words thrown in as noise
    task automatic pull_index(input int noise_pct);
        do begin
            if ($urandom_range(99) < noise_pct) begin
                case ($urandom_range(2))
                    0:       send_word(cffis_pkg::MODE_APPEND, 8'($urandom));
                    1:       send_word(cffis_pkg::MODE_CLOSE, 8'($urandom));
                    default: send_word(MODE_IGNORED, 8'($urandom));
                endcase
            end
            send_word(cffis_pkg::MODE_PULL, 8'($urandom));
        end while (emitting);
    endtask

    // Mostly small indexes, now and then a wider one, sometimes with an open tail
    task automatic random_index();
        int n_members;
        n_members = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 5);
        for (int i = 0; i < n_members; i++)
            load_member(($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6),
                        1'b1);
        if ($urandom_range(3) == 0)
            load_member($urandom_range(1, 5), 1'b0);
        pull_index(8);
    endtask

    initial begin
        int quota;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty index, with an ignored word ahead of it and loading words mid-stream
        send_word(MODE_IGNORED, 8'hff);
        send_word(cffis_pkg::MODE_PULL, 8'h00);
        send_word(cffis_pkg::MODE_APPEND, 8'haa);
        send_word(cffis_pkg::MODE_CLOSE, 8'h00);
        send_word(MODE_IGNORED, 8'h00);
        send_word(cffis_pkg::MODE_PULL, 8'hff);

        // one empty member: no data, last lands on the final offset
        send_word(cffis_pkg::MODE_CLOSE, 8'h00);
        pull_index(0);

        // extreme bytes, an empty member between, an open member closed by the pull
        send_word(cffis_pkg::MODE_APPEND, 8'h00);
        send_word(cffis_pkg::MODE_CLOSE, 8'hff);
        send_word(cffis_pkg::MODE_CLOSE, 8'h00);
        send_word(cffis_pkg::MODE_APPEND, 8'hff);
        send_word(cffis_pkg::MODE_APPEND, 8'h5a);
        pull_index(0);

        // random indexes under each idling mix
        for (int p = 0; p < 4; p++) begin
            gap_pct   = gap_plan[p];
            stall_pct = stall_plan[p];
            quota     = items_taken + PHASE_ITEMS;
            while (items_taken < quota)
                random_index();
        end

        // member table full: the extra close and append are dropped
        for (int i = 0; i < MAX_MEMBERS; i++)
            load_member((i % 64 == 0) ? 1 : 0, 1'b1);
        send_word(cffis_pkg::MODE_CLOSE, 8'($urandom));
        send_word(cffis_pkg::MODE_APPEND, 8'($urandom));
        pull_index(4);

        // drain and let the pipeline settle
        s_valid <= 1'b0;
        while (pending != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        $display("built and read back %0d indexes (%0d with dropped input), %0d input words",
                 indexes_done, dropped_indexes, items_taken);
        $display("%0d result words compared across four idling mixes and a full member table",
                 words_checked);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
